// ----- src/pars_pkg.sv -----
// Package for the pinned address range set: command codes, field widths,
// parameter defaults and the result word type. No dependencies.
package pars_pkg;

   // parameter defaults
   localparam int CAPACITY_DEF  = 32;
   localparam int ADDR_BITS_DEF = 48;

   // fixed field widths
   localparam int START_W  = 32;
   localparam int LEN_W    = 32;
   localparam int HDR_W    = 16;
   localparam int OFFSET_W = 32;

   typedef enum logic [1:0] {
      CMD_PUT     = 2'd0,
      CMD_HAS     = 2'd1,
      CMD_OFFSETS = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   // one result word
   typedef struct packed {
      logic                hit;
      logic [OFFSET_W-1:0] offset;
      logic                offset_valid;
      logic                dropped;
      logic                last;
   } rsp_type;

   function automatic rsp_type make_rsp(input logic                hit,
                                        input logic [OFFSET_W-1:0] offset,
                                        input logic                offset_valid,
                                        input logic                dropped,
                                        input logic                last);
      rsp_type r;
      r.hit          = hit;
      r.offset       = offset;
      r.offset_valid = offset_valid;
      r.dropped      = dropped;
      r.last         = last;
      return r;
   endfunction

endpackage

// ----- src/pinned_address_range_set.sv -----
// Pinned address range set: sorted address store with range and offset queries.
// Clear and zero insert answer from ST_LO. Queries and offset listings run ST_LO, ST_HI,
// ST_SCAN, ST_DRAIN, offsets one a cycle in the scan. Inserts run ST_LO, ST_SCAN, ST_DRAIN
// (end of duplicate or refused ones), ST_SHIFT and ST_SHWR if entries move up, ST_PUT.
// A new word is taken while the final result shows; results are never held off.
// Reset is synchronous and empties the set at once (fill count, no clearing pass).
module pinned_address_range_set #(
   parameter int CAPACITY  = pars_pkg::CAPACITY_DEF,
   parameter int ADDR_BITS = pars_pkg::ADDR_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_cmd,
   input  logic [ADDR_BITS-1:0]          req_address,
   input  logic [pars_pkg::START_W-1:0]  req_start_req,
   input  logic [pars_pkg::LEN_W-1:0]    req_length,
   input  logic [pars_pkg::HDR_W-1:0]    req_header,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic [pars_pkg::OFFSET_W-1:0] rsp_offset,
   output logic                          rsp_offset_valid,
   output logic                          rsp_dropped,
   output logic                          rsp_last
);

   localparam int IW   = $clog2(CAPACITY);
   localparam int CNTW = $clog2(CAPACITY + 1);
   localparam int LOW  = pars_pkg::START_W + 1;
   localparam int HIW  = LOW + 1;
   localparam int CW   = (ADDR_BITS > HIW) ? ADDR_BITS : HIW;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LO, ST_HI, ST_SCAN, ST_DRAIN, ST_SHIFT, ST_SHWR, ST_PUT
   } state_type;

   state_type                     state_ff;
   logic [CNTW-1:0]               count_ff;
   pars_pkg::cmd_type             cmd_ff;
   logic [ADDR_BITS-1:0]          base_ff;
   logic [pars_pkg::START_W-1:0]  start_ff;
   logic [pars_pkg::LEN_W-1:0]    len_ff;
   logic [pars_pkg::HDR_W-1:0]    hdr_ff;
   logic [LOW-1:0]                lo_ff;
   logic [HIW-1:0]                hi_ff;
   logic [CNTW-1:0]               sc_ff;
   logic [CNTW-1:0]               lim_ff;
   logic                          rd_vld_ff;
   logic                          rd_shift_ff;
   logic [IW-1:0]                 rd_idx_ff;
   logic                          d_vld_ff;
   logic [ADDR_BITS:0]            diff_ff;
   logic                          dup_ff;
   logic [CNTW-1:0]               lt_cnt_ff;
   logic                          hit_ff;
   logic                          pend_ff;
   logic [pars_pkg::OFFSET_W-1:0] pend_off_ff;
   pars_pkg::rsp_type             rsp_ff;
   logic                          rsp_valid_ff;

   logic                          rd_en;
   logic                          wr_en;
   logic [IW-1:0]                 wr_addr;
   logic [ADDR_BITS-1:0]          wr_data;
   logic [ADDR_BITS-1:0]          rd_data;
   logic [ADDR_BITS:0]            diff_in;
   logic [CW-1:0]                 d_ext;
   logic                          less;
   logic                          eq;
   logic                          in_win;
   logic [pars_pkg::OFFSET_W-1:0] off_in;

   // sorted address store, ascending in slots 0 .. count-1
   pars_ram #(
      .WIDTH (ADDR_BITS),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (sc_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   // issue reads while scanning or moving entries up
   assign rd_en = ((state_ff == ST_SCAN) && (sc_ff != lim_ff)) || (state_ff == ST_SHIFT);

   // write moved entries one slot up, then the new address at its place
   assign wr_en   = (state_ff == ST_PUT) || (rd_vld_ff && rd_shift_ff);
   assign wr_addr = (state_ff == ST_PUT) ? lt_cnt_ff[IW-1:0] : IW'(rd_idx_ff + 1'b1);
   assign wr_data = (state_ff == ST_PUT) ? base_ff : rd_data;

   // shared subtractor: entry minus base, borrow marks entry below base
   assign diff_in = {1'b0, rd_data} - {1'b0, base_ff};

   // compare stage on the registered difference
   assign less   = diff_ff[ADDR_BITS];
   assign eq     = (diff_ff == '0);
   assign d_ext  = CW'(diff_ff[ADDR_BITS-1:0]);
   assign in_win = !less && (d_ext >= CW'(lo_ff)) && (d_ext < CW'(hi_ff));
   assign off_in = d_ext[pars_pkg::OFFSET_W-1:0] - pars_pkg::OFFSET_W'(hdr_ff);

   // sequencer, scan pipeline and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         d_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= rd_en;
         rd_shift_ff  <= (state_ff == ST_SHIFT);
         rd_idx_ff    <= sc_ff[IW-1:0];
         d_vld_ff     <= rd_vld_ff && !rd_shift_ff;
         diff_ff      <= diff_in;

         // accumulate per entry; stream offsets one behind to mark the last
         if (d_vld_ff) begin
            dup_ff <= dup_ff | eq;
            if (less) begin
               lt_cnt_ff <= lt_cnt_ff + 1'b1;
            end
            if (in_win) begin
               hit_ff <= 1'b1;
               if (cmd_ff == pars_pkg::CMD_OFFSETS) begin
                  if (pend_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff <= pars_pkg::make_rsp(1'b0, pend_off_ff, 1'b1, 1'b0, 1'b0);
                  end
                  pend_ff     <= 1'b1;
                  pend_off_ff <= off_in;
               end
            end
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  cmd_ff   <= pars_pkg::cmd_type'(req_cmd);
                  base_ff  <= req_address;
                  start_ff <= req_start_req;
                  len_ff   <= req_length;
                  hdr_ff   <= req_header;
                  state_ff <= ST_LO;
               end
            end
            ST_LO: begin
               dup_ff    <= 1'b0;
               lt_cnt_ff <= '0;
               hit_ff    <= 1'b0;
               pend_ff   <= 1'b0;
               sc_ff     <= '0;
               if (cmd_ff == pars_pkg::CMD_HAS) begin
                  lo_ff <= LOW'(start_ff) + LOW'(hdr_ff);
               end else begin
                  lo_ff <= LOW'(hdr_ff);
               end
               unique case (cmd_ff)
                  pars_pkg::CMD_CLEAR: begin
                     count_ff     <= '0;
                     rsp_valid_ff <= 1'b1;
                     rsp_ff   <= pars_pkg::make_rsp(1'b0, '0, 1'b0, 1'b0, 1'b1);
                     state_ff <= ST_IDLE;
                  end
                  pars_pkg::CMD_PUT: begin
                     if (base_ff == '0) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_ff   <= pars_pkg::make_rsp(1'b0, '0, 1'b0, 1'b0, 1'b1);
                        state_ff <= ST_IDLE;
                     end else begin
                        lim_ff   <= count_ff;
                        state_ff <= ST_SCAN;
                     end
                  end
                  pars_pkg::CMD_HAS, pars_pkg::CMD_OFFSETS: begin
                     lim_ff   <= (base_ff == '0) ? '0 : count_ff;
                     state_ff <= ST_HI;
                  end
               endcase
            end
            ST_HI: begin
               hi_ff    <= HIW'(lo_ff) + HIW'(len_ff);
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (sc_ff == lim_ff) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  sc_ff <= sc_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               if (!rd_vld_ff && !d_vld_ff) begin
                  unique case (cmd_ff)
                     pars_pkg::CMD_HAS: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_ff   <= pars_pkg::make_rsp(hit_ff, '0, 1'b0, 1'b0, 1'b1);
                        state_ff <= ST_IDLE;
                     end
                     pars_pkg::CMD_OFFSETS: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_ff <= pend_ff ?
                           pars_pkg::make_rsp(1'b0, pend_off_ff, 1'b1, 1'b0, 1'b1) :
                           pars_pkg::make_rsp(1'b0, '0, 1'b0, 1'b0, 1'b1);
                        state_ff <= ST_IDLE;
                     end
                     pars_pkg::CMD_PUT: begin
                        priority if (dup_ff) begin
                           rsp_valid_ff <= 1'b1;
                           rsp_ff   <= pars_pkg::make_rsp(1'b0, '0, 1'b0, 1'b0, 1'b1);
                           state_ff <= ST_IDLE;
                        end else if (count_ff == CNTW'(CAPACITY)) begin
                           rsp_valid_ff <= 1'b1;
                           rsp_ff   <= pars_pkg::make_rsp(1'b0, '0, 1'b0, 1'b1, 1'b1);
                           state_ff <= ST_IDLE;
                        end else if (lt_cnt_ff == count_ff) begin
                           state_ff <= ST_PUT;
                        end else begin
                           sc_ff    <= CNTW'(count_ff - 1'b1);
                           state_ff <= ST_SHIFT;
                        end
                     end
                     pars_pkg::CMD_CLEAR: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_SHIFT: begin
               if (sc_ff == lt_cnt_ff) begin
                  state_ff <= ST_SHWR;
               end else begin
                  sc_ff <= sc_ff - 1'b1;
               end
            end
            ST_SHWR: begin
               // last moved entry is written this cycle
               state_ff <= ST_PUT;
            end
            ST_PUT: begin
               count_ff     <= count_ff + 1'b1;
               rsp_valid_ff <= 1'b1;
               rsp_ff       <= pars_pkg::make_rsp(1'b0, '0, 1'b0, 1'b0, 1'b1);
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_ff.hit;
   assign rsp_offset       = rsp_ff.offset;
   assign rsp_offset_valid = rsp_ff.offset_valid;
   assign rsp_dropped      = rsp_ff.dropped;
   assign rsp_last         = rsp_ff.last;

endmodule

// ----- src/pars_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module pars_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/pars_checker.sv -----
// Port-level checks for the pinned address range set, bound to the top level.
// Depends on pinned_address_range_set port names.
module pars_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_hit,
   input logic rsp_offset_valid,
   input logic rsp_dropped,
   input logic rsp_last
);

   // an accepted word makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   // the final result of a command is followed by a quiet cycle
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result right after a final result");

   // more results pending means the block is still working
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final result while idle");

   // going idle always delivers the final result
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid && rsp_last)
      else $error("idle without final result");

   // hit and dropped results are single and carry no offset
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_hit || rsp_dropped) |-> rsp_last && !rsp_offset_valid)
      else $error("hit or dropped result malformed");

endmodule

bind pinned_address_range_set pars_checker u_pars_checker (.*);
